// ===== src/i2cbe_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
`default_nettype none

package i2cbe_pkg;

  localparam int unsigned I2CBE_QUEUE_DEPTH = 2;

  localparam logic [15:0] LONG_TICKS_RESET  = 16'd5;
  localparam logic [15:0] SHORT_TICKS_RESET = 16'd1;
  localparam logic [7:0]  POLL_LIMIT_RESET  = 8'd250;

  // register indexes on the configuration port
  localparam logic [1:0] REG_LONG_TICKS  = 2'd0;
  localparam logic [1:0] REG_SHORT_TICKS = 2'd1;
  localparam logic [1:0] REG_POLL_LIMIT  = 2'd2;

  // action codes of an input item
  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_WAIT  = 3'd4;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_item_t;

  typedef enum logic [2:0] {
    CK_NONE,
    CK_START,
    CK_STOP,
    CK_WRITE,
    CK_READ,
    CK_WAIT
  } cmd_kind_t;

  // decoded tick as it sits in the queue between front and back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_item_t;

  typedef struct packed {
    logic [15:0] long_ticks;
    logic [15:0] short_ticks;
    logic [7:0]  poll_limit;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_WA_REL  = 5'd4,
    PH_WA_HIGH = 5'd5,
    PH_WA_POLL = 5'd6,
    PH_WR_SET  = 5'd7,
    PH_WR_HIGH = 5'd8,
    PH_WR_LOW  = 5'd9,
    PH_RD_HIGH = 5'd10,
    PH_RD_LOW  = 5'd11,
    PH_AK_SET  = 5'd12,
    PH_AK_HIGH = 5'd13,
    PH_AK_LOW  = 5'd14
  } phase_t;

endpackage

`default_nettype wire

// ===== src/i2cbe_fifo.sv =====
// Small register queue with a count, used on both sides of the engine.
`default_nettype none

module i2cbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2cbe_front.sv =====
// Front end: takes ticks, decodes the command and queues them for the engine.
`default_nettype none

module i2cbe_front
  import i2cbe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = I2CBE_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cmd_item_t cmd,
  output logic           full,
  output logic           tick_valid,
  input  wire logic      tick_ready,
  output tick_item_t     tick
);

  tick_item_t decoded;
  logic       q_empty;

  always_comb begin
    decoded.tx_byte  = cmd.tx_byte;
    decoded.send_ack = cmd.send_ack;
    decoded.sda_in   = cmd.sda_in;
    decoded.kind     = CK_NONE;
    if (cmd.cmd_valid) begin
      case (cmd.action)
        ACT_START: decoded.kind = CK_START;
        ACT_STOP:  decoded.kind = CK_STOP;
        ACT_WRITE: decoded.kind = CK_WRITE;
        ACT_READ:  decoded.kind = CK_READ;
        ACT_WAIT:  decoded.kind = CK_WAIT;
        default:   decoded.kind = CK_NONE;
      endcase
    end
  end

  i2cbe_fifo #(
    .WIDTH($bits(tick_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_tick_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(decoded),
    .full (full),
    .pop  (tick_ready),
    .rdata(tick),
    .empty(q_empty)
  );

  assign tick_valid = ~q_empty;

endmodule

`default_nettype wire

// ===== src/i2cbe_back.sv =====
// Back end: bus phase sequencer, one tick per step, results into an output queue.
`default_nettype none

module i2cbe_back
  import i2cbe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = I2CBE_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       tick_valid,
  output logic            tick_ready,
  input  wire tick_item_t tick,
  output logic            empty,
  input  wire logic       pop,
  output res_item_t       res
);

  phase_t      phase, phase_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic [2:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  poll_counter, poll_counter_next;
  logic        scl_line, scl_line_next;
  logic        sda_line, sda_line_next;
  logic        ack_flag, ack_flag_next;
  logic        ack_choice, ack_choice_next;
  logic [7:0]  rx_last, rx_last_next;
  logic        done_now;

  logic        out_full;
  logic        step;
  logic [15:0] long_len;
  logic [15:0] short_len;
  logic [15:0] tick_dec;
  res_item_t   result;

  assign tick_ready = ~out_full;
  assign step       = tick_valid & ~out_full;
  // a zero length register behaves as one tick
  assign long_len   = (cfg.long_ticks == '0) ? 16'd1 : cfg.long_ticks;
  assign short_len  = (cfg.short_ticks == '0) ? 16'd1 : cfg.short_ticks;
  assign tick_dec   = (tick_counter != '0) ? tick_counter - 16'd1 : tick_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= '0;
      bit_counter  <= '0;
      shift_reg    <= '0;
      poll_counter <= '0;
      scl_line     <= 1'b1;
      sda_line     <= 1'b1;
      ack_flag     <= 1'b0;
      ack_choice   <= 1'b0;
      rx_last      <= '0;
    end else if (step) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_counter  <= bit_counter_next;
      shift_reg    <= shift_reg_next;
      poll_counter <= poll_counter_next;
      scl_line     <= scl_line_next;
      sda_line     <= sda_line_next;
      ack_flag     <= ack_flag_next;
      ack_choice   <= ack_choice_next;
      rx_last      <= rx_last_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bit_counter_next  = bit_counter;
    shift_reg_next    = shift_reg;
    poll_counter_next = poll_counter;
    scl_line_next     = scl_line;
    sda_line_next     = sda_line;
    ack_flag_next     = ack_flag;
    ack_choice_next   = ack_choice;
    rx_last_next      = rx_last;
    done_now          = 1'b0;

    if (phase == PH_IDLE) begin
      unique case (tick.kind)
        CK_START: begin
          phase_next = PH_ST_A; scl_line_next = 1'b1; sda_line_next = 1'b1;
          tick_counter_next = long_len;
        end
        CK_STOP: begin
          phase_next = PH_SP_A; scl_line_next = 1'b1; sda_line_next = 1'b0;
          tick_counter_next = long_len;
        end
        CK_WRITE: begin
          shift_reg_next = tick.tx_byte; bit_counter_next = '0;
          phase_next = PH_WR_SET; scl_line_next = 1'b0;
          sda_line_next = tick.tx_byte[7]; tick_counter_next = short_len;
        end
        CK_READ: begin
          shift_reg_next = '0; bit_counter_next = '0;
          ack_choice_next = tick.send_ack;
          phase_next = PH_RD_HIGH; scl_line_next = 1'b1; sda_line_next = 1'b1;
          tick_counter_next = long_len;
        end
        CK_WAIT: begin
          phase_next = PH_WA_REL; sda_line_next = 1'b1;
          tick_counter_next = long_len;
        end
        CK_NONE: ;
        default: ;
      endcase
    end else if (phase == PH_WA_POLL) begin
      if (!tick.sda_in || poll_counter >= cfg.poll_limit) begin
        ack_flag_next     = tick.sda_in;
        phase_next        = PH_IDLE;
        scl_line_next     = 1'b0;
        tick_counter_next = '0;
        done_now          = 1'b1;
      end else begin
        poll_counter_next = poll_counter + 8'd1;
      end
    end else begin
      tick_counter_next = tick_dec;
      if (tick_dec == '0) begin
        unique case (phase)
          PH_ST_A: begin
            phase_next = PH_ST_B; scl_line_next = 1'b1; sda_line_next = 1'b0;
            tick_counter_next = long_len;
          end
          PH_ST_B: begin
            phase_next = PH_IDLE; scl_line_next = 1'b0; sda_line_next = 1'b0;
            done_now = 1'b1;
          end
          PH_SP_A: begin
            phase_next = PH_IDLE; scl_line_next = 1'b1; sda_line_next = 1'b1;
            done_now = 1'b1;
          end
          PH_WA_REL: begin
            phase_next = PH_WA_HIGH; scl_line_next = 1'b1; sda_line_next = 1'b1;
            tick_counter_next = long_len;
          end
          PH_WA_HIGH: begin
            phase_next = PH_WA_POLL; poll_counter_next = '0;
          end
          PH_WR_SET: begin
            phase_next = PH_WR_HIGH; scl_line_next = 1'b1;
            tick_counter_next = long_len;
          end
          PH_WR_HIGH: begin
            phase_next = PH_WR_LOW; scl_line_next = 1'b0;
            tick_counter_next = short_len;
          end
          PH_WR_LOW: begin
            if (bit_counter == 3'd7) begin
              phase_next = PH_IDLE; scl_line_next = 1'b0; sda_line_next = 1'b1;
              done_now = 1'b1;
            end else begin
              bit_counter_next = bit_counter + 3'd1;
              shift_reg_next   = {shift_reg[6:0], 1'b0};
              phase_next = PH_WR_SET; scl_line_next = 1'b0;
              sda_line_next = shift_reg[6]; tick_counter_next = short_len;
            end
          end
          PH_RD_HIGH: begin
            shift_reg_next = {shift_reg[6:0], tick.sda_in};
            phase_next = PH_RD_LOW; scl_line_next = 1'b0; sda_line_next = 1'b1;
            tick_counter_next = long_len;
          end
          PH_RD_LOW: begin
            if (bit_counter == 3'd7) begin
              rx_last_next = shift_reg;
              phase_next = PH_AK_SET; scl_line_next = 1'b0;
              sda_line_next = ~ack_choice; tick_counter_next = long_len;
            end else begin
              bit_counter_next = bit_counter + 3'd1;
              phase_next = PH_RD_HIGH; scl_line_next = 1'b1; sda_line_next = 1'b1;
              tick_counter_next = long_len;
            end
          end
          PH_AK_SET: begin
            phase_next = PH_AK_HIGH; scl_line_next = 1'b1;
            tick_counter_next = long_len;
          end
          PH_AK_HIGH: begin
            phase_next = PH_AK_LOW; scl_line_next = 1'b0;
            tick_counter_next = long_len;
          end
          PH_AK_LOW: begin
            phase_next = PH_IDLE; scl_line_next = 1'b0; sda_line_next = 1'b1;
            done_now = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.scl_level  = scl_line_next;
    result.sda_level  = sda_line_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done_now;
    result.rx_byte    = rx_last_next;
    result.ack_failed = ack_flag_next;
  end

  i2cbe_fifo #(
    .WIDTH($bits(res_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (step),
    .wdata(result),
    .full (out_full),
    .pop  (pop),
    .rdata(res),
    .empty(empty)
  );

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: register file and the two halves.
//
// Each input item is one bus tick: an optional command (start, stop, write
// byte, read byte, wait for ack) plus the sampled SDA level. Every tick gives
// exactly one result item with the open-drain SCL/SDA levels, busy, a done
// pulse, the last received byte and the ack failure flag.
// Input channel: push/full/cmd, item taken when push is high and full low.
// Result channel: empty/pop/res, the oldest result shows while empty is low.
// Path: a tick waits in the tick queue, then one engine step writes its result
// into the result queue, from which it can be popped. Throughput is one tick
// per cycle while the result queue is not full, set by the phase step of the
// back end.
// When the receiver stalls, the result queue fills, the engine holds, and
// then the tick queue fills and full rises; nothing is dropped.
// Reset empties both queues, puts the engine idle with both lines released
// and loads the phase lengths 5 and 1 and the poll limit 250.
// Registers (APB, byte addresses): 0 long phase ticks, 4 short phase ticks,
// 8 ack poll limit. Write them only while no command is running.
`default_nettype none

module i2c_master_bit_engine
  import i2cbe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = I2CBE_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  input  wire cmd_item_t   cmd,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output res_item_t        res
);

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       tick_valid;
  logic       tick_ready;
  tick_item_t tick;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_ticks  <= LONG_TICKS_RESET;
      cfg.short_ticks <= SHORT_TICKS_RESET;
      cfg.poll_limit  <= POLL_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LONG_TICKS:  cfg.long_ticks  <= pwdata[15:0];
        REG_SHORT_TICKS: cfg.short_ticks <= pwdata[15:0];
        REG_POLL_LIMIT:  cfg.poll_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LONG_TICKS:  prdata = {16'd0, cfg.long_ticks};
      REG_SHORT_TICKS: prdata = {16'd0, cfg.short_ticks};
      REG_POLL_LIMIT:  prdata = {24'd0, cfg.poll_limit};
      default:         prdata = '0;
    endcase
  end

  i2cbe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd       (cmd),
    .full      (full),
    .tick_valid(tick_valid),
    .tick_ready(tick_ready),
    .tick      (tick)
  );

  i2cbe_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tick_valid(tick_valid),
    .tick_ready(tick_ready),
    .tick      (tick),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule

`default_nettype wire
